// ----- rtl/lfpp_pkg.sv -----
// Types and constants shared by the lidar frame point parser.
`default_nettype none
package lfpp_pkg;

    localparam int HEADER_LEN = 16;
    localparam int FULL_TURN  = 36000;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_FRAME  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V1_FORMAT   = 2'd3;

    localparam logic [3:0] MIN_OFFSET_NIBBLE = 4'd3;
    localparam logic [1:0] LAST_PHASE        = 2'd3;
    localparam logic [1:0] TALLY_MAX         = 2'd3;
    localparam logic [1:0] TALLY_MIN_GOOD    = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       datagram_end;
    } item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] quality;
        logic [15:0] angle_centideg;
        logic        scan_sync;
        logic        frame_end;
        logic        laser_fault;
    } point_t;

    typedef struct packed {
        logic [15:0] preamble_word;
        logic [3:0]  device_type_code;
        logic [3:0]  data_frame_code;
        logic [3:0]  v1_format_code;
    } cfg_t;

    typedef enum logic {
        OP_HEADER,
        OP_POINT
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic               div_en;
        logic signed [16:0] div_num;
        logic [15:0]        div_den;
        logic [15:0]        distance;
        logic [15:0]        quality;
        logic [7:0]         step_byte;
        logic [15:0]        start_angle;
        logic               first;
        logic               last;
        logic               sync;
        logic               v1;
    } op_t;

endpackage
`default_nettype wire

// ----- rtl/lfpp_front.sv -----
// Front end: byte position tracking, header capture and check, point assembly.
`default_nettype none
module lfpp_front #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lfpp_pkg::cfg_t cfg,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire lfpp_pkg::item_t item,
    output logic                op_valid,
    output lfpp_pkg::op_t       op,
    input  wire logic           op_full
);
    import lfpp_pkg::*;

    localparam int PW = $clog2(MAX_DATAGRAM_BYTES + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    hdr_reg [HEADER_LEN];
    logic          good_reg, good_next;
    logic [15:0]   pnum_reg, pnum_next;
    logic [23:0]   hold_reg, hold_next;

    logic          accept;
    logic          in_range, is_hdr, hdr_last, hdr_ok, v1_now, in_data, last_pt;
    logic [15:0]   count, start_angle, end_angle;
    logic [PW-1:0] data_start, rel;
    logic [16:0]   pnum_inc;

    assign item_stall = op_full;
    assign accept     = item_valid && !op_full;

    assign in_range    = pos_reg < PW'(MAX_DATAGRAM_BYTES);
    assign is_hdr      = pos_reg < PW'(HEADER_LEN);
    assign hdr_last    = pos_reg == PW'(HEADER_LEN - 1);
    assign count       = {hdr_reg[12], hdr_reg[13]};
    assign start_angle = {hdr_reg[10], hdr_reg[11]};
    assign end_angle   = {hdr_reg[14], item.data_byte};
    assign v1_now      = hdr_reg[8][3:0] == cfg.v1_format_code;
    assign hdr_ok      = ({hdr_reg[0], hdr_reg[1]} == cfg.preamble_word)
                      && (hdr_reg[2][7:4] == cfg.device_type_code)
                      && (hdr_reg[2][3:0] == cfg.data_frame_code)
                      && (count != 16'd0)
                      && (hdr_reg[3][7:4] >= MIN_OFFSET_NIBBLE);
    assign data_start  = PW'({hdr_reg[3][7:4], 2'b00}) + PW'(4);
    assign in_data     = pos_reg >= data_start;
    assign rel         = pos_reg - data_start;
    assign pnum_inc    = {1'b0, pnum_reg} + 17'd1;
    assign last_pt     = pnum_inc >= {1'b0, count};

    always_comb
    begin
        pos_next  = pos_reg;
        good_next = good_reg;
        pnum_next = pnum_reg;
        hold_next = hold_reg;
        op_valid  = 1'b0;
        op        = '0;
        op.kind        = OP_POINT;
        op.distance    = {hold_reg[7:0], item.data_byte};
        op.quality     = v1_now ? hold_reg[23:8] : {8'd0, hold_reg[23:16]};
        op.step_byte   = hold_reg[15:8];
        op.start_angle = start_angle;
        op.first       = pnum_reg == 16'd0;
        op.last        = last_pt;
        op.sync        = last_pt && (hdr_reg[8][7:4] != 4'd0);
        op.v1          = v1_now;
        op.div_en      = v1_now && (count >= 16'd2);
        op.div_num     = $signed({1'b0, end_angle}) - $signed({1'b0, start_angle});
        op.div_den     = count - 16'd1;
        if (accept)
        begin
            if (in_range)
            begin
                pos_next = pos_reg + PW'(1);
                if (is_hdr)
                begin
                    if (hdr_last)
                    begin
                        good_next = hdr_ok;
                        if (hdr_ok)
                        begin
                            pnum_next = '0;
                            hold_next = '0;
                            op_valid  = 1'b1;
                            op.kind   = OP_HEADER;
                        end
                    end
                end
                else if (good_reg && in_data)
                begin
                    if (rel[1:0] != LAST_PHASE)
                    begin
                        hold_next = {hold_reg[15:0], item.data_byte};
                    end
                    else
                    begin
                        op_valid = 1'b1;
                        if (last_pt)
                        begin
                            good_next = 1'b0;
                            pnum_next = '0;
                        end
                        else
                        begin
                            pnum_next = pnum_inc[15:0];
                        end
                    end
                end
            end
            if (item.datagram_end)
            begin
                pos_next  = '0;
                good_next = 1'b0;
                pnum_next = '0;
                hold_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            good_reg <= 1'b0;
            pnum_reg <= '0;
            hold_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            good_reg <= good_next;
            pnum_reg <= pnum_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range && is_hdr)
        begin
            hdr_reg[pos_reg[3:0]] <= item.data_byte;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfpp_fifo.sv -----
// Two-entry queue of work words between front and back.
`default_nettype none
module lfpp_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire lfpp_pkg::op_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output lfpp_pkg::op_t      rd_data,
    output logic               not_empty
);
    import lfpp_pkg::*;

    op_t        mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_data   = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfpp_div.sv -----
// Signed divider for the V1 angle step, one quotient bit a cycle, truncating.
`default_nettype none
module lfpp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [16:0] num,
    input  wire logic        [15:0] den,
    output logic                    busy,
    output logic                    done,
    output logic signed [16:0]      quotient
);
    logic        busy_reg, done_reg, neg_reg;
    logic [3:0]  cnt_reg;
    logic [16:0] rem_reg, rem_shift, mag;
    logic [15:0] quo_reg, den_reg;

    assign mag       = num[16] ? 17'(-num) : 17'(num);
    assign rem_shift = {rem_reg[15:0], quo_reg[15]};
    assign busy      = busy_reg || done_reg;
    assign done      = done_reg;
    assign quotient  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd15;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag[15:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[16];
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_reg <= rem_shift - {1'b0, den_reg};
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfpp_back.sv -----
// Back end: angle step, angle wrap, nonzero tally and the output register.
`default_nettype none
module lfpp_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      op_valid,
    input  wire lfpp_pkg::op_t op,
    output logic           op_pop,
    output logic           point_valid,
    input  wire logic      point_stall,
    output lfpp_pkg::point_t point
);
    import lfpp_pkg::*;

    localparam logic signed [18:0] TURN1 = 19'(FULL_TURN);
    localparam logic signed [18:0] TURN2 = 19'(2 * FULL_TURN);

    function automatic logic [15:0] wrap_turn(input logic signed [18:0] s);
        logic signed [18:0] r;
        begin
            if (s < 0)
            begin
                r = (s + TURN1 < 0) ? s + TURN2 : s + TURN1;
            end
            else if (s >= TURN2)
            begin
                r = s - TURN2;
            end
            else if (s >= TURN1)
            begin
                r = s - TURN1;
            end
            else
            begin
                r = s;
            end
            return r[15:0];
        end
    endfunction

    logic signed [16:0] step_reg;
    logic [15:0]        acc_reg;
    logic [1:0]         tally_reg, tally_inc;
    point_t             out_reg;
    logic               out_valid_reg;

    logic               div_start, div_busy, div_done, out_free, pop_point;
    logic signed [16:0] div_q;
    logic signed [18:0] sum;
    logic [15:0]        ang;

    lfpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (op.div_num),
        .den      (op.div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free  = !out_valid_reg || !point_stall;
    assign op_pop    = op_valid && !div_busy && ((op.kind == OP_HEADER) || out_free);
    assign pop_point = op_pop && (op.kind == OP_POINT);
    assign div_start = op_pop && (op.kind == OP_HEADER) && op.div_en;

    always_comb
    begin
        if (op.first)
        begin
            sum = $signed({3'b000, op.start_angle});
        end
        else if (op.v1)
        begin
            sum = $signed({3'b000, acc_reg}) + 19'(step_reg);
        end
        else
        begin
            sum = $signed({3'b000, acc_reg}) + $signed({11'd0, op.step_byte});
        end
        ang = wrap_turn(sum);
        tally_inc = ((op.distance != 16'd0) && (tally_reg != TALLY_MAX))
                  ? tally_reg + 2'd1 : tally_reg;
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            acc_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (div_done)
            begin
                step_reg <= div_q;
            end
            else if (op_pop && (op.kind == OP_HEADER) && !op.div_en)
            begin
                step_reg <= '0;
            end
            if (pop_point)
            begin
                acc_reg       <= op.last ? 16'd0 : ang;
                tally_reg     <= op.sync ? 2'd0 : tally_inc;
                out_valid_reg <= 1'b1;
            end
            else if (!point_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_point)
        begin
            out_reg.distance       <= op.distance;
            out_reg.quality        <= op.quality;
            out_reg.angle_centideg <= ang;
            out_reg.scan_sync      <= op.sync;
            out_reg.frame_end      <= op.last;
            out_reg.laser_fault    <= op.sync && (tally_inc < TALLY_MIN_GOOD);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lidar_frame_point_parser_top.sv -----
// A point passes through the work queue and then the output register after its last byte is accepted.
// Throughput: one byte per cycle while the work queue has room; a V1 header starts the
// step divider, which holds the work queue while busy and so stalls bytes after it.
// Reset (rst_n, async, low): position, frame state, queue, tally and
// configuration registers clear; header bytes hold no reset.
`default_nettype none
module lidar_frame_point_parser_top #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [lfpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfpp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire lfpp_pkg::item_t                 item,
    output logic                                 point_valid,
    input  wire logic                            point_stall,
    output lfpp_pkg::point_t                     point
);
    import lfpp_pkg::*;

    cfg_t cfg_reg;
    op_t  fr_op, q_op;
    logic fr_valid, q_full, q_pop, q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PREAMBLE:    cfg_reg.preamble_word    <= cfg_data;
                CFG_DEVICE_TYPE: cfg_reg.device_type_code <= cfg_data[3:0];
                CFG_DATA_FRAME:  cfg_reg.data_frame_code  <= cfg_data[3:0];
                CFG_V1_FORMAT:   cfg_reg.v1_format_code   <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    lfpp_front #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .op_valid   (fr_valid),
        .op         (fr_op),
        .op_full    (q_full)
    );

    lfpp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fr_valid),
        .wr_data   (fr_op),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_op),
        .not_empty (q_valid)
    );

    lfpp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (q_valid),
        .op          (q_op),
        .op_pop      (q_pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the lidar frame point parser.
`timescale 1ns / 100ps
module testbench;
    import lfpp_pkg::*;

    localparam int MAX_BYTES = 2048;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_WORDS = 750;

    typedef struct {
        item_t  word;
        bit     typed;
        point_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        point_valid;
    logic        point_stall = 1'b0;
    point_t      point;

    // model of the parser state
    logic [15:0] m_preamble;
    logic [3:0]  m_device, m_frame, m_v1code;
    int          m_pos;
    logic [7:0]  m_hdr [16];
    bit          m_good;
    int          m_pnum;
    logic [23:0] m_hold;
    int          m_acc, m_step, m_tally;

    point_t      pending_points [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          random_words = 0;
    bit          hold_req = 1'b0;
    int          stall_pct = 0;
    int          rcv_count = 0;
    row_t        directed [$];
    logic [7:0]  frame_bytes [$];

    lidar_frame_point_parser_top #(.MAX_DATAGRAM_BYTES(MAX_BYTES)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point)
    );

    always #5 clk = ~clk;

    function automatic int hdr_word(int i);
        return {m_hdr[i], m_hdr[i+1]};
    endfunction

    function automatic bit hdr_is_v1();
        return m_hdr[8][3:0] == m_v1code;
    endfunction

    function automatic int wrap_angle(int a);
        int r;
        r = a % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        return r;
    endfunction

    // Advance the parser model by one word; return 1 when a point comes out.
    function automatic bit parse_word(item_t w, output point_t p);
        int  first_pos, cnt, ang;
        bit  got;
        got = 1'b0;
        p = '0;
        if (m_pos < MAX_BYTES) begin
            if (m_pos < HEADER_LEN) begin
                m_hdr[m_pos] = w.data_byte;
                if (m_pos == HEADER_LEN - 1) begin
                    cnt = hdr_word(12);
                    m_good = 1'b0;
                    if (hdr_word(0) == m_preamble && m_hdr[2][7:4] == m_device
                        && m_hdr[2][3:0] == m_frame && cnt >= 1
                        && m_hdr[3][7:4] >= MIN_OFFSET_NIBBLE) begin
                        m_good = 1'b1;
                        m_pnum = 0;
                        m_hold = '0;
                        m_acc = 0;
                        m_step = 0;
                        if (hdr_is_v1() && cnt >= 2)
                            m_step = (hdr_word(14) - hdr_word(10)) / (cnt - 1);
                    end
                end
            end else if (m_good) begin
                first_pos = (m_hdr[3][7:4] + 1) * 4;
                if (m_pos >= first_pos) begin
                    if (((m_pos - first_pos) & 3) < 3) begin
                        m_hold = {m_hold[15:0], w.data_byte};
                    end else begin
                        got = 1'b1;
                        cnt = hdr_word(12);
                        p.distance = {m_hold[7:0], w.data_byte};
                        if (p.distance != 0 && m_tally < 3)
                            m_tally++;
                        p.quality = hdr_is_v1() ? {m_hold[23:16], m_hold[15:8]}
                                                : {8'h00, m_hold[23:16]};
                        if (m_pnum == 0)
                            ang = wrap_angle(hdr_word(10));
                        else
                            ang = wrap_angle(m_acc + (hdr_is_v1() ? m_step
                                                                  : int'(m_hold[15:8])));
                        m_acc = ang;
                        p.angle_centideg = ang[15:0];
                        m_pnum++;
                        if (m_pnum >= cnt) begin
                            p.frame_end = 1'b1;
                            if (m_hdr[8][7:4] != 0) begin
                                p.scan_sync = 1'b1;
                                p.laser_fault = m_tally < 2;
                                m_tally = 0;
                            end
                            m_good = 1'b0;
                            m_pnum = 0;
                            m_acc = 0;
                        end
                    end
                end
            end
            m_pos++;
        end
        if (w.datagram_end) begin
            m_pos = 0;
            m_good = 1'b0;
            m_pnum = 0;
            m_hold = '0;
            m_acc = 0;
        end
        return got;
    endfunction

    // Offer one word, idling between bursts; hold it until accepted.
    task automatic send_word(item_t w, bit typed, point_t want);
        point_t p;
        if (burst_left == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (item_stall);
        if (parse_word(w, p))
            pending_points.push_back(typed ? want : p);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_PREAMBLE:    m_preamble = val;
            CFG_DEVICE_TYPE: m_device = val[3:0];
            CFG_DATA_FRAME:  m_frame = val[3:0];
            default:         m_v1code = val[3:0];
        endcase
    endtask

    task automatic set_config(logic [15:0] pre, logic [3:0] dev, logic [3:0] frm,
                              logic [3:0] v1c);
        write_reg(CFG_PREAMBLE, pre);
        write_reg(CFG_DEVICE_TYPE, {12'h000, dev});
        write_reg(CFG_DATA_FRAME, {12'h000, frm});
        write_reg(CFG_V1_FORMAT, {12'h000, v1c});
        cfg_write_en <= 1'b0;
    endtask

    // Build one datagram: mostly well formed, some noise, bad, cut short or with trailing bytes.
    task automatic build_frame(int force_points);
        int  flavor, npts, nib, total, i;
        logic [7:0] b;
        frame_bytes.delete();
        flavor = $urandom_range(0, 9);
        if (flavor == 0 && force_points == 0) begin
            repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
            return;
        end
        if (force_points != 0)
            npts = force_points;
        else if ($urandom_range(0, 19) == 0)
            npts = 0;
        else
            npts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                               : $urandom_range(1, 6);
        nib = ($urandom_range(0, 9) == 0 && force_points == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 6);
        frame_bytes.push_back(m_preamble[15:8]);
        frame_bytes.push_back(m_preamble[7:0]);
        frame_bytes.push_back({m_device, m_frame});
        frame_bytes.push_back({nib[3:0], 4'($urandom)});
        repeat (4) frame_bytes.push_back(8'($urandom));
        b = 8'($urandom);
        if ($urandom_range(0, 1))
            b[3:0] = m_v1code;
        else
            b[3:0] = m_v1code + 4'($urandom_range(1, 15));
        if ($urandom_range(0, 2) == 0)
            b[7:4] = 4'h0;
        frame_bytes.push_back(b);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(npts[15:8]);
        frame_bytes.push_back(npts[7:0]);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        for (i = HEADER_LEN; i < (nib + 1) * 4; i++)
            frame_bytes.push_back(8'($urandom));
        for (i = 0; i < npts; i++) begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 2) == 0) begin
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(8'h00);
            end else begin
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(8'($urandom));
            end
        end
        if (flavor == 1) begin
            // corrupt one header field
            i = $urandom_range(0, 4);
            i = (i == 4) ? 13 : i;
            frame_bytes[i] = frame_bytes[i] ^ 8'($urandom_range(1, 255));
        end else if (flavor == 2) begin
            total = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > total)
                void'(frame_bytes.pop_back());
        end else if (flavor == 3) begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_frame();
        item_t  w;
        point_t none;
        none = '0;
        foreach (frame_bytes[i]) begin
            w.data_byte = frame_bytes[i];
            w.datagram_end = (i == frame_bytes.size() - 1);
            send_word(w, 1'b0, none);
            random_words++;
        end
    endtask

    task automatic add_row(logic [7:0] b, bit last, bit typed, point_t want);
        row_t r;
        r.word.data_byte = b;
        r.word.datagram_end = last;
        r.typed = typed;
        r.want = want;
        directed.push_back(r);
    endtask

    // receiver: stall pattern of its own, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                point_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end else begin
                rcv_count++;
                if (rcv_count % 50 == 0)
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 70;
                        default: stall_pct = 95;
                    endcase
                point_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (point_valid && !point_stall) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point %p", point);
            end else begin
                if (point !== pending_points[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected %p, got %p",
                                 pending_points[0], point);
                end
                void'(pending_points.pop_front());
            end
        end
    end

    // watchdog on cycles with no word moving on either side and no config write
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (point_valid && !point_stall) || cfg_write_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        point_t p0, p1, p2;
        int     phase;
        m_preamble = '0;
        m_device = '0;
        m_frame = '0;
        m_v1code = '0;
        m_pos = 0;
        m_good = 1'b0;
        m_pnum = 0;
        m_hold = '0;
        m_acc = 0;
        m_step = 0;
        m_tally = 0;
        foreach (m_hdr[i])
            m_hdr[i] = '0;

        // reset config: all-zero codes, non-V1 frame with sync, 2 points
        p0 = '0;
        p1 = '{distance: 16'hFFFF, quality: 16'h00FF, angle_centideg: 16'd100,
               scan_sync: 1'b0, frame_end: 1'b0, laser_fault: 1'b0};
        p2 = '{distance: 16'h0000, quality: 16'h0001, angle_centideg: 16'd355,
               scan_sync: 1'b1, frame_end: 1'b1, laser_fault: 1'b1};
        add_row(8'h00, 0, 0, p0); add_row(8'h00, 0, 0, p0);
        add_row(8'h00, 0, 0, p0); add_row(8'h30, 0, 0, p0);
        add_row(8'hFF, 0, 0, p0); add_row(8'h00, 0, 0, p0);
        add_row(8'hFF, 0, 0, p0); add_row(8'h00, 0, 0, p0);
        add_row(8'h11, 0, 0, p0); add_row(8'hFF, 0, 0, p0);
        add_row(8'h00, 0, 0, p0); add_row(8'h64, 0, 0, p0);
        add_row(8'h00, 0, 0, p0); add_row(8'h02, 0, 0, p0);
        add_row(8'h00, 0, 0, p0); add_row(8'h00, 0, 0, p0);
        add_row(8'hFF, 0, 0, p0); add_row(8'h05, 0, 0, p0);
        add_row(8'hFF, 0, 0, p0); add_row(8'hFF, 0, 1, p1);
        add_row(8'h01, 0, 0, p0); add_row(8'hFF, 0, 0, p0);
        add_row(8'h00, 0, 0, p0); add_row(8'h00, 1, 1, p2);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_word(directed[i].word, directed[i].typed, directed[i].want);
        drain();

        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            case (phase)
                0:       set_config(16'hFFFF, 4'hF, 4'hF, 4'hF);
                1:       set_config(16'h0000, 4'h0, 4'h0, 4'h0);
                default: set_config(16'($urandom), 4'($urandom), 4'($urandom),
                                    4'($urandom));
            endcase
            if (phase == 1) begin
                hold_req = 1'b1;
                build_frame(60);
                send_frame();
            end
            repeat (8) begin
                if (random_words < RANDOM_WORDS) begin
                    build_frame(0);
                    send_frame();
                end
            end
            drain();
            phase++;
        end
        drain();

        if (mismatches == 0 && pending_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
